// ----- sv/rgm_pkg.sv -----
`default_nettype none

package rgm_pkg;

    // Number of fractional exponent bits, one multiply step each
    localparam int unsigned NUM_STEPS = 16;

    // log2(10)/20 in Q24
    localparam logic [21:0] LOG2_10_OVER_20_Q24 = 22'd2786635;

    // Configuration register indexes
    localparam logic [2:0] CFG_PREFER_ALBUM     = 3'd0;
    localparam logic [2:0] CFG_PREAMP_EN        = 3'd1;
    localparam logic [2:0] CFG_PREAMP_GAIN_DB   = 3'd2;
    localparam logic [2:0] CFG_FALLBACK_GAIN_DB = 3'd3;
    localparam logic [2:0] CFG_APPLY_PEAK_LIMIT = 3'd4;

    // Gain source codes
    localparam logic [1:0] SRC_FALLBACK = 2'd0;
    localparam logic [1:0] SRC_ALBUM    = 2'd1;
    localparam logic [1:0] SRC_TRACK    = 2'd2;

    // Payload carried along the exponent and reciprocal pipeline
    typedef struct packed {
        logic [1:0]         src;
        logic               puse;
        logic [15:0]        den;
        logic signed [6:0]  ip;
        logic [15:0]        f;
        logic [31:0]        m;
        logic [15:0]        rem;
        logic [31:0]        num;
        logic [31:0]        q;
    } t_pipe;

    // Integer square root, rounding down
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int n = 0; n < 32; n++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q30 factor 2^(2^-k), k = 1..16, built by repeated square roots
    function automatic logic [31:0] tab_entry(input int unsigned k);
        logic [63:0] t;
        t = isqrt64(64'd1 << 61);
        for (int unsigned j = 2; j <= k; j++) begin
            t = isqrt64(t << 30);
        end
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/rgm_exp_step.sv -----
`default_nettype none

module rgm_exp_step (
    input  wire logic [31:0] i_m,
    input  wire logic [31:0] i_coef,
    input  wire logic        i_bit,
    output logic [31:0]      o_m
);

    logic [63:0] prod;
    logic [63:0] rnd;

    // Multiply by the Q30 factor and round back to Q30 when the bit is set
    always_comb begin
        prod = {32'd0, i_m} * {32'd0, i_coef};
        rnd  = prod + (64'd1 << 29);
        o_m  = i_bit ? rnd[61:30] : i_m;
    end

endmodule

`default_nettype wire

// ----- sv/rgm_div_step.sv -----
`default_nettype none

module rgm_div_step (
    input  wire logic [15:0] i_den,
    input  wire logic [15:0] i_rem,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_q,
    output logic [15:0]      o_rem,
    output logic [31:0]      o_num,
    output logic [31:0]      o_q
);

    logic [16:0] part;
    logic [15:0] rem;
    logic [31:0] num;
    logic [31:0] q;
    logic        ge;

    // Two restoring division steps, quotient bits from the top down
    always_comb begin
        rem = i_rem;
        num = i_num;
        q   = i_q;
        for (int n = 0; n < 2; n++) begin
            part = {rem, num[31]};
            ge   = (part >= {1'b0, i_den});
            if (ge) begin
                part = part - {1'b0, i_den};
            end
            rem = part[15:0];
            num = {num[30:0], 1'b0};
            q   = {q[30:0], ge};
        end
        o_rem = rem;
        o_num = num;
        o_q   = q;
    end

endmodule

`default_nettype wire

// ----- sv/replay_gain_multiplier_unit.sv -----
// Replay gain multiplier unit.
// Input items arrive on the s_axis channel: album and track gain (1/256 dB)
// and peak (Q2.14), each with a present flag. Each item gives one result on
// m_axis: a Q16 linear multiplier with peak-limited and saturated flags in
// tdata and the chosen gain source in tuser.
// Settings are written on the cfg channel (index, data); it is always ready
// and should be written only while no item is in flight.
// There are 20 register stages: input selection, one dB-to-log2 multiply,
// sixteen exponent steps (one 32x32 multiply each, running beside a
// two-bit-per-stage reciprocal divider), a rounding shift and a
// clip/saturate output register. One item is accepted every cycle while
// the output is not stalled.
// When m_axis_tready is low with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
// Reset clears all settings to zero and empties the pipeline.
`default_nettype none

module replay_gain_multiplier_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // alb_gain_db[14:0], alb_gain_ok[15], alb_pk[31:16],
    // alb_pk_ok[32], trk_gain_db[47:33], trk_gain_ok[48],
    // trk_pk[64:49], trk_pk_ok[65], zero[71:66]
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // multiplier[23:0], peak_limited[24], saturated[25], zero[31:26]
    output logic [31:0]      m_axis_tdata,
    // gain_source[1:0]
    output logic [1:0]       m_axis_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [14:0] i_cfg_data
);

    localparam int unsigned NS = rgm_pkg::NUM_STEPS;

    logic en;

    // Configuration registers
    logic        r_prefer_album;
    logic        r_preamp_en;
    logic [14:0] r_preamp_gain_db;
    logic [14:0] r_fallback_gain_db;
    logic        r_apply_peak_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefer_album     <= 1'b0;
            r_preamp_en        <= 1'b0;
            r_preamp_gain_db   <= 15'd0;
            r_fallback_gain_db <= 15'd0;
            r_apply_peak_limit <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                rgm_pkg::CFG_PREFER_ALBUM:     r_prefer_album     <= i_cfg_data[0];
                rgm_pkg::CFG_PREAMP_EN:        r_preamp_en        <= i_cfg_data[0];
                rgm_pkg::CFG_PREAMP_GAIN_DB:   r_preamp_gain_db   <= i_cfg_data;
                rgm_pkg::CFG_FALLBACK_GAIN_DB: r_fallback_gain_db <= i_cfg_data;
                rgm_pkg::CFG_APPLY_PEAK_LIMIT: r_apply_peak_limit <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline advances as one while the output register can move
    logic r_o_vld;
    assign en            = !r_o_vld || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: pick the source and form the gain in dB
    logic        a_ok;
    logic        t_ok;
    logic [1:0]  n_s1_src;
    logic [16:0] n_s1_g;
    logic [15:0] n_s1_peak;
    logic        n_s1_puse;
    logic [16:0] sel_g;
    logic        sel_pok;

    logic               r_s1_vld;
    logic [1:0]         r_s1_src;
    logic signed [16:0] r_s1_g;
    logic [15:0]        r_s1_peak;
    logic               r_s1_puse;

    always_comb begin
        a_ok = s_axis_tdata[15];
        t_ok = s_axis_tdata[48];
        if (r_prefer_album) begin
            n_s1_src = a_ok ? rgm_pkg::SRC_ALBUM
                     : (t_ok ? rgm_pkg::SRC_TRACK : rgm_pkg::SRC_FALLBACK);
        end else begin
            n_s1_src = t_ok ? rgm_pkg::SRC_TRACK
                     : (a_ok ? rgm_pkg::SRC_ALBUM : rgm_pkg::SRC_FALLBACK);
        end
        if (n_s1_src == rgm_pkg::SRC_ALBUM) begin
            sel_g     = {{2{s_axis_tdata[14]}}, s_axis_tdata[14:0]};
            n_s1_peak = s_axis_tdata[31:16];
            sel_pok   = s_axis_tdata[32];
        end else begin
            sel_g     = {{2{s_axis_tdata[47]}}, s_axis_tdata[47:33]};
            n_s1_peak = s_axis_tdata[64:49];
            sel_pok   = s_axis_tdata[65];
        end
        if (n_s1_src == rgm_pkg::SRC_FALLBACK) begin
            n_s1_g    = {{2{r_fallback_gain_db[14]}}, r_fallback_gain_db};
            n_s1_puse = 1'b0;
        end else begin
            n_s1_g = sel_g + (r_preamp_en
                     ? {{2{r_preamp_gain_db[14]}}, r_preamp_gain_db} : 17'd0);
            n_s1_puse = r_apply_peak_limit && sel_pok && (n_s1_peak != 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_src  <= n_s1_src;
            r_s1_g    <= n_s1_g;
            r_s1_peak <= n_s1_peak;
            r_s1_puse <= n_s1_puse;
        end
    end

    // Stage 2: convert dB to log2 in Q16, seed the exponent and divider
    logic signed [39:0] prod_db;
    logic signed [39:0] v_db;
    rgm_pkg::t_pipe     n_p0;

    always_comb begin
        prod_db    = r_s1_g * $signed({1'b0, rgm_pkg::LOG2_10_OVER_20_Q24});
        v_db       = prod_db + 40'sd32768;
        n_p0.src   = r_s1_src;
        n_p0.puse  = r_s1_puse;
        n_p0.den   = r_s1_peak;
        n_p0.ip    = v_db[38:32];
        n_p0.f     = v_db[31:16];
        n_p0.m     = 32'd1 << 30;
        n_p0.rem   = 16'd0;
        n_p0.num   = (32'd1 << 30) + {17'd0, r_s1_peak[15:1]};
        n_p0.q     = 32'd0;
    end

    logic           r_vld  [0:NS];
    rgm_pkg::t_pipe r_pipe [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pipe[0] <= n_p0;
        end
    end

    // Exponent steps with the reciprocal division alongside
    for (genvar k = 1; k <= NS; k++) begin : g_step
        localparam logic [31:0] COEF = rgm_pkg::tab_entry(k);
        rgm_pkg::t_pipe n_p;
        logic [31:0]    m_nx;
        logic [15:0]    rem_nx;
        logic [31:0]    num_nx;
        logic [31:0]    q_nx;

        rgm_exp_step u_exp (
            .i_m    (r_pipe[k-1].m),
            .i_coef (COEF),
            .i_bit  (r_pipe[k-1].f[NS-k]),
            .o_m    (m_nx)
        );

        rgm_div_step u_div (
            .i_den (r_pipe[k-1].den),
            .i_rem (r_pipe[k-1].rem),
            .i_num (r_pipe[k-1].num),
            .i_q   (r_pipe[k-1].q),
            .o_rem (rem_nx),
            .o_num (num_nx),
            .o_q   (q_nx)
        );

        always_comb begin
            n_p     = r_pipe[k-1];
            n_p.m   = m_nx;
            n_p.rem = rem_nx;
            n_p.num = num_nx;
            n_p.q   = q_nx;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pipe[k] <= n_p;
            end
        end
    end

    // Shift stage: apply the integer part of the exponent with rounding
    logic signed [8:0] sh;
    logic [8:0]        sh_neg;
    logic [40:0]       rnd_w;
    logic [39:0]       n_sh_raw;

    logic        r_sh_vld;
    logic [39:0] r_sh_raw;
    logic [30:0] r_sh_q;
    logic        r_sh_puse;
    logic [1:0]  r_sh_src;

    always_comb begin
        sh     = 9'sd14 - {{2{r_pipe[NS].ip[6]}}, r_pipe[NS].ip};
        sh_neg = 9'd0 - sh;
        rnd_w  = 41'd0;
        if (sh <= 9'sd0) begin
            if (sh_neg >= 9'd8) begin
                n_sh_raw = '1;
            end else begin
                n_sh_raw = {8'd0, r_pipe[NS].m} << sh_neg[2:0];
            end
        end else if (sh > 9'sd40) begin
            n_sh_raw = 40'd0;
        end else begin
            rnd_w    = {9'd0, r_pipe[NS].m} + (41'd1 << (sh[5:0] - 6'd1));
            n_sh_raw = 40'(rnd_w >> sh[5:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_vld <= 1'b0;
        end else if (en) begin
            r_sh_vld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sh_raw  <= n_sh_raw;
            r_sh_q    <= r_pipe[NS].q[30:0];
            r_sh_puse <= r_pipe[NS].puse;
            r_sh_src  <= r_pipe[NS].src;
        end
    end

    // Output stage: clip to 1/peak, then saturate to 24 bits
    logic        clip;
    logic [39:0] val;
    logic        sat;
    logic [23:0] r_o_mult;
    logic        r_o_lim;
    logic        r_o_sat;
    logic [1:0]  r_o_src;

    always_comb begin
        clip = r_sh_puse && ({9'd0, r_sh_q} < r_sh_raw);
        val  = clip ? {9'd0, r_sh_q} : r_sh_raw;
        sat  = (val > 40'hFF_FFFF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_sh_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_mult <= sat ? 24'hFF_FFFF : val[23:0];
            r_o_lim  <= clip;
            r_o_sat  <= sat;
            r_o_src  <= r_sh_src;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {6'd0, r_o_sat, r_o_lim, r_o_mult};
    assign m_axis_tuser  = r_o_src;

endmodule

`default_nettype wire

// ----- sim/tb_replay_gain_multiplier_unit.sv -----
`timescale 1ns / 100ps

module tb_replay_gain_multiplier_unit;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [14:0] alb_gain;
        logic               alb_gain_ok;
        logic [15:0]        alb_pk;
        logic               alb_pk_ok;
        logic signed [14:0] trk_gain;
        logic               trk_gain_ok;
        logic [15:0]        trk_pk;
        logic               trk_pk_ok;
    } t_gain_tags;

    typedef struct {
        logic [23:0] mult;
        logic [1:0]  src;
        logic        limited;
        logic        sat;
    } t_gain_out;

    typedef struct {
        logic               prefer_album;
        logic               preamp_en;
        logic signed [14:0] preamp;
        logic signed [14:0] fallback;
        logic               apply_limit;
    } t_gain_cfg;

    typedef struct {
        int         cfg_sel;
        t_gain_tags tags;
        logic       known;
        t_gain_out  want;
    } t_tag_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_addr = '0;
    logic [14:0] i_cfg_data = '0;

    logic [63:0] root_tab [1:16];
    t_gain_cfg   cur_cfg;
    t_gain_out   pending_gains [$];
    t_tag_row    tag_rows [$];
    t_gain_cfg   row_cfgs [3];
    int          fails = 0;
    int          cycles = 0;
    logic        quiet = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_cnt = 0;

    replay_gain_multiplier_unit DUT (.*);

    always #6 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Floor square root, one bit at a time
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    // Linear Q16 gain from 1/256 dB, before saturation
    function automatic logic [63:0] lin_from_db(input int g);
        longint      v;
        longint      t;
        longint      ip;
        longint      s;
        logic [15:0] f;
        logic [63:0] m;
        v = longint'(g) * 2786635 + 32768;
        t = v >>> 16;
        ip = t >>> 16;
        f = t[15:0];
        m = 64'd1 << 30;
        for (int i = 1; i <= 16; i++)
            if (f[16 - i]) m = (m * root_tab[i] + (64'd1 << 29)) >> 30;
        s = 14 - ip;
        if (s <= 0) begin
            if (-s > 20) return 64'd1 << 50;
            return m << (-s);
        end
        if (s > 40) return '0;
        return (m + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic t_gain_out predict_gain(input t_gain_tags x, input t_gain_cfg c);
        t_gain_out   o;
        logic [63:0] raw;
        logic [63:0] recip;
        logic [15:0] peak;
        logic        peak_ok;
        int          g;
        o = '{default: '0};
        if (c.prefer_album)
            o.src = x.alb_gain_ok ? rgm_pkg::SRC_ALBUM
                  : (x.trk_gain_ok ? rgm_pkg::SRC_TRACK : rgm_pkg::SRC_FALLBACK);
        else
            o.src = x.trk_gain_ok ? rgm_pkg::SRC_TRACK
                  : (x.alb_gain_ok ? rgm_pkg::SRC_ALBUM : rgm_pkg::SRC_FALLBACK);
        if (o.src == rgm_pkg::SRC_FALLBACK) begin
            raw = lin_from_db(int'(c.fallback));
        end else begin
            if (o.src == rgm_pkg::SRC_ALBUM) begin
                g = int'(x.alb_gain);
                peak = x.alb_pk;
                peak_ok = x.alb_pk_ok;
            end else begin
                g = int'(x.trk_gain);
                peak = x.trk_pk;
                peak_ok = x.trk_pk_ok;
            end
            if (c.preamp_en) g += int'(c.preamp);
            raw = lin_from_db(g);
            if (c.apply_limit && peak_ok && peak != 0) begin
                recip = ((64'd1 << 30) + (peak >> 1)) / peak;
                if (recip < raw) begin
                    raw = recip;
                    o.limited = 1'b1;
                end
            end
        end
        if (raw > 64'hFF_FFFF) begin
            raw = 64'hFF_FFFF;
            o.sat = 1'b1;
        end
        o.mult = raw[23:0];
        return o;
    endfunction

    function automatic t_gain_tags mk_tags(input int ag, input bit agv, input int ap,
                                           input bit apv, input int tg, input bit tgv,
                                           input int tp, input bit tpv);
        return '{15'(ag), agv, 16'(ap), apv, 15'(tg), tgv, 16'(tp), tpv};
    endfunction

    function automatic t_gain_tags rand_tags();
        t_gain_tags x;
        x = mk_tags($urandom, $urandom_range(1), $urandom, $urandom_range(1),
                    $urandom, $urandom_range(1), $urandom, $urandom_range(1));
        // keep most gains near unity so the exponent stays in range
        if ($urandom_range(99) < 60) x.alb_gain = 15'($urandom_range(6000) - 3000);
        if ($urandom_range(99) < 60) x.trk_gain = 15'($urandom_range(6000) - 3000);
        if ($urandom_range(9) == 0) x.alb_pk = '0;
        if ($urandom_range(9) == 0) x.trk_pk = 16'hFFFF;
        return x;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // Check each result item against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_gains.size() == 0) begin
                report("unexpected item", m_axis_tdata, '0);
            end else begin
                if (m_axis_tdata[23:0] != pending_gains[0].mult)
                    report("multiplier", 32'(m_axis_tdata[23:0]),
                           32'(pending_gains[0].mult));
                if (m_axis_tuser != pending_gains[0].src)
                    report("gain_source", 32'(m_axis_tuser), 32'(pending_gains[0].src));
                if (m_axis_tdata[24] != pending_gains[0].limited)
                    report("peak_limited", 32'(m_axis_tdata[24]),
                           32'(pending_gains[0].limited));
                if (m_axis_tdata[25] != pending_gains[0].sat)
                    report("saturated", 32'(m_axis_tdata[25]), 32'(pending_gains[0].sat));
                void'(pending_gains.pop_front());
            end
        end
    end

    // Result side: random stalls, one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= 32);
        end
    end

    task automatic send_tags(input t_gain_tags x, input logic known, input t_gain_out want);
        if (!quiet) begin
            while ($urandom_range(99) < 32) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, x.trk_pk_ok, x.trk_pk, x.trk_gain_ok, x.trk_gain,
                         x.alb_pk_ok, x.alb_pk, x.alb_gain_ok, x.alb_gain};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_gains.push_back(known ? want : predict_gain(x, cur_cfg));
        @(negedge i_clk);
    endtask

    // Wait until every result is back and the pipeline has run empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_gains.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_cfg(input t_gain_cfg c);
        logic [2:0]  addrs [6];
        logic [14:0] vals [6];
        drain();
        addrs = '{rgm_pkg::CFG_PREFER_ALBUM, rgm_pkg::CFG_PREAMP_EN,
                  rgm_pkg::CFG_PREAMP_GAIN_DB, rgm_pkg::CFG_FALLBACK_GAIN_DB,
                  rgm_pkg::CFG_APPLY_PEAK_LIMIT,
                  3'(rgm_pkg::CFG_APPLY_PEAK_LIMIT + $urandom_range(1, 3))};
        vals = '{15'(c.prefer_album), 15'(c.preamp_en), c.preamp, c.fallback,
                 15'(c.apply_limit), 15'($urandom)};
        for (int i = 0; i < 6; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_addr <= addrs[i];
            i_cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    initial begin
        t_gain_cfg c;
        int        sel;
        root_tab[1] = floor_sqrt(64'd1 << 61);
        for (int i = 2; i <= 16; i++) root_tab[i] = floor_sqrt(root_tab[i - 1] << 30);
        cur_cfg = '{default: '0};
        row_cfgs[0] = '{1'b0, 1'b0, 15'sd0, 15'sd0, 1'b0};
        row_cfgs[1] = '{1'b1, 1'b1, 15'sd16383, -15'sd16384, 1'b1};
        row_cfgs[2] = '{1'b1, 1'b1, -15'sd16384, 15'sd16383, 1'b0};

        // Directed cases: unity, fallback, saturation, peak clip, underflow
        tag_rows.push_back('{0, mk_tags(0, 0, 0, 0, 0, 1, 0, 0), 1,
                             '{24'h01_0000, rgm_pkg::SRC_TRACK, 1'b0, 1'b0}});
        tag_rows.push_back('{0, mk_tags(0, 0, 0, 0, 0, 0, 0, 0), 1,
                             '{24'h01_0000, rgm_pkg::SRC_FALLBACK, 1'b0, 1'b0}});
        tag_rows.push_back('{0, mk_tags(0, 1, 0, 0, 5, 0, 0, 0), 1,
                             '{24'h01_0000, rgm_pkg::SRC_ALBUM, 1'b0, 1'b0}});
        tag_rows.push_back('{0, mk_tags(-16384, 1, 0, 1, 16383, 1, 65535, 1), 1,
                             '{24'hFF_FFFF, rgm_pkg::SRC_TRACK, 1'b0, 1'b1}});
        tag_rows.push_back('{0, mk_tags(16383, 1, 65535, 1, -16384, 1, 0, 1), 0, '{default: '0}});
        tag_rows.push_back('{0, mk_tags(-1, 1, 16384, 1, 0, 0, 16384, 1), 0, '{default: '0}});
        tag_rows.push_back('{1, mk_tags(16383, 1, 65535, 1, 0, 1, 0, 0), 0, '{default: '0}});
        tag_rows.push_back('{1, mk_tags(1000, 1, 0, 1, 0, 1, 1, 1), 0, '{default: '0}});
        tag_rows.push_back('{1, mk_tags(1000, 1, 1, 0, 0, 1, 1, 1), 0, '{default: '0}});
        tag_rows.push_back('{1, mk_tags(0, 0, 1, 1, 0, 0, 1, 1), 0, '{default: '0}});
        tag_rows.push_back('{1, mk_tags(-16384, 1, 8192, 1, 0, 0, 0, 0), 0, '{default: '0}});
        tag_rows.push_back('{1, mk_tags(0, 0, 0, 0, -3000, 1, 20000, 1), 0, '{default: '0}});
        tag_rows.push_back('{1, mk_tags(-2000, 1, 1, 1, 0, 1, 0, 0), 0, '{default: '0}});
        tag_rows.push_back('{2, mk_tags(0, 0, 0, 0, 0, 0, 0, 0), 1,
                             '{24'hFF_FFFF, rgm_pkg::SRC_FALLBACK, 1'b0, 1'b1}});
        tag_rows.push_back('{2, mk_tags(-16384, 1, 0, 0, 0, 0, 0, 0), 1,
                             '{24'h00_0000, rgm_pkg::SRC_ALBUM, 1'b0, 1'b0}});
        tag_rows.push_back('{2, mk_tags(0, 0, 0, 0, 16383, 1, 100, 1), 0, '{default: '0}});

        // Hold reset, then release on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        sel = 0;
        foreach (tag_rows[i]) begin
            if (tag_rows[i].cfg_sel != sel) begin
                sel = tag_rows[i].cfg_sel;
                load_cfg(row_cfgs[sel]);
            end
            send_tags(tag_rows[i].tags, tag_rows[i].known, tag_rows[i].want);
        end

        // Random phases, each with its own settings
        for (int p = 0; p < 6; p++) begin
            c = '{1'($urandom), 1'($urandom), 15'($urandom_range(4000) - 2000),
                  15'($urandom), 1'($urandom)};
            if (p == 0) c = '{1'b0, 1'b1, 15'sd16383, -15'sd16384, 1'b1};
            if (p == 1) c = '{1'b1, 1'b1, -15'sd16384, 15'sd16383, 1'b1};
            if (p == 5) c.preamp = 15'($urandom);
            load_cfg(c);
            quiet = (p == 3);
            if (p == 2) hold_req = 1'b1;
            for (int n = 0; n < 100; n++) send_tags(rand_tags(), 1'b0, '{default: '0});
        end
        quiet = 1'b0;

        drain();
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
